@@ hw/rtl/mvt_pkg.sv @@
package mvt_pkg;

   // Field widths of the stream words.
   localparam int CMD_W   = 2;
   localparam int SLOT_W  = 8;
   localparam int IDX_W   = 24;
   localparam int DIST_W  = 32;
   localparam int COUNT_W = 16;
   localparam int REQ_W   = 104;
   localparam int IMG_W   = 8;
   localparam int VOTE_W  = 16;
   localparam int RSP_W   = 24;

   // Configuration register widths.
   localparam int ICNT_W = 9;
   localparam int KLIM_W = 5;
   localparam int PCT_W  = 7;

   // Threshold product: percentage times descriptor count.
   localparam int PROD_W = 23;
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
   localparam logic [VOTE_W-1:0] VOTE_MAX = 16'hFFFF;

   // Register reset values.
   localparam logic [ICNT_W-1:0] ICNT_RST = 9'd256;
   localparam logic [KLIM_W-1:0] KLIM_RST = 5'd16;
   localparam logic [PCT_W-1:0]  PCT_RST  = 7'd0;
   localparam logic [DIST_W-1:0] DTHR_RST = 32'd3277;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_COUNT = 2'd0,
      CSR_K_LIMIT     = 2'd1,
      CSR_MIN_PCT     = 2'd2,
      CSR_DIST_THR    = 2'd3
   } csr_index_type;

   // Input command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_MATCH  = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Work kinds passed from front to back.
   typedef enum logic [1:0] {
      JOB_LOAD   = 2'd0,
      JOB_VOTE   = 2'd1,
      JOB_FINISH = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type        kind;
      logic [SLOT_W-1:0]   slot;
      logic [IDX_W-1:0]    value;
      logic [COUNT_W-1:0]  count;
   } job_type;

   typedef struct packed {
      logic [ICNT_W-1:0] image_count;
      logic [KLIM_W-1:0] k_limit;
      logic [PCT_W-1:0]  min_pct;
      logic [DIST_W-1:0] dist_thr;
   } cfg_type;

endpackage

@@ hw/rtl/mvt_front.sv @@
module mvt_front
   import mvt_pkg::*;
#(
   parameter int MAX_IMAGES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [CMD_W-1:0]   in_cmd,
   input  logic [REQ_W-1:0]   in_data,
   input  logic [DIST_W-1:0]  dist_thr,
   input  logic               hold,
   input  logic               q_full,
   output logic               push,
   output job_type            job
);

   logic [SLOT_W-1:0]  slot;
   logic [IDX_W-1:0]   range_end;
   logic [IDX_W-1:0]   nbr_index;
   logic [DIST_W-1:0]  distance;
   logic [COUNT_W-1:0] desc_count;
   logic               take;

   assign slot       = in_data[7:0];
   assign range_end  = in_data[31:8];
   assign nbr_index  = in_data[55:32];
   assign distance   = in_data[87:56];
   assign desc_count = in_data[103:88];

   // Words are taken whenever the queue has room and the back end is not clearing.
   assign in_ready = !q_full && !hold;
   assign take     = in_valid && in_ready;

   // Classify the word; dropped words never reach the queue.
   always_comb begin
      push      = 1'b0;
      job.kind  = JOB_LOAD;
      job.slot  = slot;
      job.value = range_end;
      job.count = desc_count;
      unique case (cmd_type'(in_cmd))
         CMD_LOAD: begin
            push = take && (32'(slot) < MAX_IMAGES);
         end
         CMD_MATCH: begin
            job.kind  = JOB_VOTE;
            job.value = nbr_index;
            push      = take && (distance < dist_thr);
         end
         CMD_FINISH: begin
            job.kind = JOB_FINISH;
            push     = take;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

@@ hw/rtl/mvt_queue.sv @@
module mvt_queue
   import mvt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type     slot_ff [2];
   logic        wr_ff;
   logic        wr_in;
   logic        rd_ff;
   logic        rd_in;
   logic [1:0]  cnt_ff;
   logic [1:0]  cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_job   = slot_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

@@ hw/rtl/mvt_back.sv @@
module mvt_back
   import mvt_pkg::*;
#(
   parameter int MAX_IMAGES = 256,
   parameter int MAX_TOP    = 16,
   parameter int INDEX_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               job_valid,
   input  job_type            job,
   output logic               pop,
   output logic               clearing,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [IMG_W-1:0]   out_image,
   output logic [VOTE_W-1:0]  out_votes,
   output logic               out_found,
   output logic               out_last
);

   localparam int IW = $clog2(MAX_IMAGES);
   localparam int CW = IW + 1;
   localparam int KW = $clog2(MAX_TOP + 1);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b00000001,
      S_IDLE   = 8'b00000010,
      S_VSCAN  = 8'b00000100,
      S_VINC   = 8'b00001000,
      S_FSTART = 8'b00010000,
      S_FSCAN  = 8'b00100000,
      S_FDEC   = 8'b01000000,
      S_FEND   = 8'b10000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           iss_ff, iss_in;
   logic                    rv_ff, rv_in;
   logic [IW-1:0]           ridx_ff, ridx_in;
   logic [INDEX_BITS-1:0]   idx_ff, idx_in;
   logic [IW-1:0]           hit_ff, hit_in;
   logic                    have_ff, have_in;
   logic [IW-1:0]           best_ff, best_in;
   logic [VOTE_W-1:0]       bestv_ff, bestv_in;
   logic [KW-1:0]           round_ff, round_in;
   logic                    pend_ff, pend_in;
   logic [IW-1:0]           pimg_ff, pimg_in;
   logic [VOTE_W-1:0]       pvote_ff, pvote_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [IW-1:0]           clr_ff, clr_in;
   logic                    ov_ff, ov_in;
   logic [IMG_W-1:0]        oimg_ff, oimg_in;
   logic [VOTE_W-1:0]       ovote_ff, ovote_in;
   logic                    ofound_ff, ofound_in;
   logic                    olast_ff, olast_in;

   // Memories and their ports.
   logic [INDEX_BITS-1:0]   range_mem [MAX_IMAGES];
   logic [VOTE_W-1:0]       vote_mem [MAX_IMAGES];
   logic [INDEX_BITS-1:0]   range_q_ff;
   logic [VOTE_W-1:0]       vote_q_ff;
   logic                    r_we;
   logic [IW-1:0]           r_waddr;
   logic [INDEX_BITS-1:0]   r_wdata;
   logic                    v_we;
   logic [IW-1:0]           v_waddr;
   logic [VOTE_W-1:0]       v_wdata;
   logic [IW-1:0]           v_raddr;

   logic [CW-1:0]           n_img;
   logic [KW-1:0]           kk;
   logic [PCT_W-1:0]        pct;
   logic                    rsp_free;
   logic [PROD_W-1:0]       best_scaled;
   logic                    unpicked;

   // Saturated configuration values.
   assign n_img = (32'(cfg.image_count) > MAX_IMAGES) ? CW'(MAX_IMAGES) : CW'(cfg.image_count);
   assign kk    = (32'(cfg.k_limit) > MAX_TOP) ? KW'(MAX_TOP) : KW'(cfg.k_limit);
   assign pct   = (cfg.min_pct > PCT_FULL) ? PCT_FULL : cfg.min_pct;

   assign rsp_free    = !ov_ff || out_ready;
   assign best_scaled = PROD_W'(bestv_ff) * PROD_W'(PCT_FULL);
   assign clearing    = (state_ff == S_CLEAR);

   // Picks come out in strict rank order (more votes first, then lower number),
   // so an image is still unpicked exactly when it ranks after the previous pick.
   assign unpicked = !pend_ff || (vote_q_ff < pvote_ff) ||
                     ((vote_q_ff == pvote_ff) && (ridx_ff > pimg_ff));

   assign out_valid = ov_ff;
   assign out_image = oimg_ff;
   assign out_votes = ovote_ff;
   assign out_found = ofound_ff;
   assign out_last  = olast_ff;

   // Sequencer for loads, vote scans, top-K rounds and the clearing pass.
   always_comb begin
      state_in  = state_ff;
      iss_in    = iss_ff;
      rv_in     = 1'b0;
      ridx_in   = ridx_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      have_in   = have_ff;
      best_in   = best_ff;
      bestv_in  = bestv_ff;
      round_in  = round_ff;
      pend_in   = pend_ff;
      pimg_in   = pimg_ff;
      pvote_in  = pvote_ff;
      prod_in   = prod_ff;
      clr_in    = clr_ff;
      ov_in     = out_ready ? 1'b0 : ov_ff;
      oimg_in   = oimg_ff;
      ovote_in  = ovote_ff;
      ofound_in = ofound_ff;
      olast_in  = olast_ff;
      pop       = 1'b0;
      r_we      = 1'b0;
      r_wdata   = INDEX_BITS'(32'(job.value));
      v_we      = 1'b0;
      v_waddr   = clr_ff;
      v_wdata   = '0;
      v_raddr   = iss_ff[IW-1:0];
      r_waddr   = IW'(32'(job.slot));

      unique case (state_ff)
         S_CLEAR: begin
            v_we   = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IW'(MAX_IMAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (job_valid) begin
               pop = 1'b1;
               unique case (job.kind)
                  JOB_LOAD: begin
                     r_we = 1'b1;
                  end
                  JOB_VOTE: begin
                     idx_in   = INDEX_BITS'(32'(job.value));
                     iss_in   = '0;
                     state_in = S_VSCAN;
                  end
                  JOB_FINISH: begin
                     prod_in  = PROD_W'(pct) * PROD_W'(job.count);
                     round_in = '0;
                     pend_in  = 1'b0;
                     state_in = S_FSTART;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_VSCAN: begin
            // First entry whose end lies above the index takes the vote.
            v_raddr = ridx_ff;
            if (iss_ff < n_img) begin
               rv_in   = 1'b1;
               ridx_in = iss_ff[IW-1:0];
               iss_in  = iss_ff + 1'b1;
            end
            if (rv_ff && (range_q_ff > idx_ff)) begin
               hit_in   = ridx_ff;
               state_in = S_VINC;
            end else if (!rv_ff && (iss_ff >= n_img)) begin
               state_in = S_IDLE;
            end
         end
         S_VINC: begin
            v_we     = 1'b1;
            v_waddr  = hit_ff;
            v_wdata  = (vote_q_ff == VOTE_MAX) ? vote_q_ff : vote_q_ff + 1'b1;
            state_in = S_IDLE;
         end
         S_FSTART: begin
            if (round_ff < kk) begin
               iss_in   = '0;
               have_in  = 1'b0;
               state_in = S_FSCAN;
            end else begin
               state_in = S_FEND;
            end
         end
         S_FSCAN: begin
            // Running maximum over unpicked images; ties keep the lower number.
            if (iss_ff < n_img) begin
               rv_in   = 1'b1;
               ridx_in = iss_ff[IW-1:0];
               iss_in  = iss_ff + 1'b1;
            end
            if (rv_ff && unpicked && (!have_ff || (vote_q_ff > bestv_ff))) begin
               have_in  = 1'b1;
               best_in  = ridx_ff;
               bestv_in = vote_q_ff;
            end
            if (!rv_ff && (iss_ff >= n_img)) begin
               state_in = S_FDEC;
            end
         end
         S_FDEC: begin
            // Votes qualify when 100 * votes exceeds percentage * count.
            if (have_ff && (best_scaled > prod_ff)) begin
               if (!pend_ff || rsp_free) begin
                  if (pend_ff) begin
                     ov_in     = 1'b1;
                     oimg_in   = IMG_W'(32'(pimg_ff));
                     ovote_in  = pvote_ff;
                     ofound_in = 1'b1;
                     olast_in  = 1'b0;
                  end
                  pend_in  = 1'b1;
                  pimg_in  = best_ff;
                  pvote_in = bestv_ff;
                  round_in = round_ff + 1'b1;
                  state_in = S_FSTART;
               end
            end else begin
               state_in = S_FEND;
            end
         end
         S_FEND: begin
            if (rsp_free) begin
               ov_in     = 1'b1;
               oimg_in   = pend_ff ? IMG_W'(32'(pimg_ff)) : '0;
               ovote_in  = pend_ff ? pvote_ff : '0;
               ofound_in = pend_ff;
               olast_in  = 1'b1;
               clr_in    = '0;
               state_in  = S_CLEAR;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         rv_ff     <= 1'b0;
         ov_ff     <= 1'b0;
         pend_ff   <= 1'b0;
         round_ff  <= '0;
         have_ff   <= 1'b0;
         iss_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         rv_ff     <= rv_in;
         ov_ff     <= ov_in;
         pend_ff   <= pend_in;
         round_ff  <= round_in;
         have_ff   <= have_in;
         iss_ff    <= iss_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ridx_ff   <= ridx_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      best_ff   <= best_in;
      bestv_ff  <= bestv_in;
      pimg_ff   <= pimg_in;
      pvote_ff  <= pvote_in;
      prod_ff   <= prod_in;
      oimg_ff   <= oimg_in;
      ovote_ff  <= ovote_in;
      ofound_ff <= ofound_in;
      olast_ff  <= olast_in;
   end

   // Range table memory.
   always_ff @(posedge clock) begin
      if (r_we) begin
         range_mem[r_waddr] <= r_wdata;
      end
      range_q_ff <= range_mem[iss_ff[IW-1:0]];
   end

   // Vote table memory.
   always_ff @(posedge clock) begin
      if (v_we) begin
         vote_mem[v_waddr] <= v_wdata;
      end
      vote_q_ff <= vote_mem[v_raddr];
   end

endmodule

@@ hw/rtl/match_vote_topk_select.sv @@
// Range load: written to the range table in the back end. Match: a linear scan of the
// range table (one read per cycle) and a read-modify-write of the vote.
// Finish: up to k_limit rounds, each a scan of the vote table (one vote table read per
// cycle), then a pass clearing all MAX_IMAGES vote table entries. A two-word queue
// decouples input. Reset is synchronous, active high; after it all MAX_IMAGES vote table
// entries are cleared while req_tready is low. Configuration writes are registered.
module match_vote_topk_select
   import mvt_pkg::*;
#(
   parameter int MAX_IMAGES = 256,
   parameter int MAX_TOP    = 16,
   parameter int INDEX_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   // Input words.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // entry_slot[7:0], range_end[31:8], neighbor_index[55:32], distance[87:56],
   // descriptor_count[103:88]
   input  logic [REQ_W-1:0]     req_tdata,
   // cmd[1:0]
   input  logic [CMD_W-1:0]     req_tuser,
   // Result words.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // image_number[7:0], vote_count[23:8]
   output logic [RSP_W-1:0]     rsp_tdata,
   // found[0]
   output logic                 rsp_tuser,
   output logic                 rsp_tlast,
   // Register writes.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIST_W-1:0]    csr_data
);

   cfg_type             cfg_ff, cfg_in;
   logic                q_push;
   job_type             q_in_job;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;
   job_type             q_head;
   logic                clearing;
   logic [IMG_W-1:0]    out_image;
   logic [VOTE_W-1:0]   out_votes;

   // Register file.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_COUNT: cfg_in.image_count = csr_data[ICNT_W-1:0];
            CSR_K_LIMIT:     cfg_in.k_limit     = csr_data[KLIM_W-1:0];
            CSR_MIN_PCT:     cfg_in.min_pct     = csr_data[PCT_W-1:0];
            CSR_DIST_THR:    cfg_in.dist_thr    = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_count <= ICNT_RST;
         cfg_ff.k_limit     <= KLIM_RST;
         cfg_ff.min_pct     <= PCT_RST;
         cfg_ff.dist_thr    <= DTHR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mvt_front #(
      .MAX_IMAGES (MAX_IMAGES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_cmd   (req_tuser),
      .in_data  (req_tdata),
      .dist_thr (cfg_ff.dist_thr),
      .hold     (clearing),
      .q_full   (q_full),
      .push     (q_push),
      .job      (q_in_job)
   );

   mvt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_in_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head)
   );

   mvt_back #(
      .MAX_IMAGES (MAX_IMAGES),
      .MAX_TOP    (MAX_TOP),
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (q_valid),
      .job       (q_head),
      .pop       (q_pop),
      .clearing  (clearing),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_image (out_image),
      .out_votes (out_votes),
      .out_found (rsp_tuser),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {out_votes, out_image};

endmodule

@@ tb/tb_match_vote_topk_select.sv @@
module tb_match_vote_topk_select;
   import mvt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_IMG      = 256;
   localparam int N_TOP      = 16;
   localparam int CYCLE_CAP  = 20_000_000;
   localparam int DRAIN_WAIT = 1200;
   localparam int HOLD_LEN   = 3000;

   typedef struct packed {
      logic [IMG_W-1:0]  image_number;
      logic [VOTE_W-1:0] vote_count;
      logic              found;
      logic              last;
   } pick_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic [CMD_W-1:0]     req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIST_W-1:0]    csr_data;

   // Predictor state: register copies, range ends and vote counters.
   logic [ICNT_W-1:0]  icnt_q;
   logic [KLIM_W-1:0]  klim_q;
   logic [PCT_W-1:0]   pct_q;
   logic [DIST_W-1:0]  dthr_q;
   logic [IDX_W-1:0]   range_ends[N_IMG];
   logic [VOTE_W-1:0]  votes[N_IMG];
   pick_type           picks_q[$];

   int  mismatches = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  cycles = 0;
   bit  hold_active = 1'b0;
   event hold_go;

   match_vote_topk_select u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Run length guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Long receiver hold-off, counted here so the sender keeps going.
   initial begin
      forever begin
         @(hold_go);
         hold_active = 1'b1;
         repeat (HOLD_LEN) @(posedge clock);
         hold_active = 1'b0;
      end
   end

   // Receiver ready with random stalls.
   always @(posedge clock) begin
      if (reset || hold_active) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare every accepted result word with the oldest expected pick.
   always @(posedge clock) begin
      pick_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tdata[23:8], rsp_tuser, rsp_tlast};
         if (picks_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word img=%0d votes=%0d found=%0b last=%0b",
                     $time, got.image_number, got.vote_count, got.found, got.last);
         end else begin
            want = picks_q.pop_front();
            if (got != want) begin
               mismatches++;
               $display("%0t: expected img=%0d votes=%0d found=%0b last=%0b,",
                        $time, want.image_number, want.vote_count, want.found, want.last,
                        " got img=%0d votes=%0d found=%0b last=%0b",
                        got.image_number, got.vote_count, got.found, got.last);
            end
         end
      end
   end

   // Top-K selection over the vote counters, then clear them.
   function automatic void predict_finish(logic [COUNT_W-1:0] count);
      int          n, kk, best, got;
      int unsigned pct, thr;
      bit          have;
      bit          picked[N_IMG];
      pick_type    p;
      n   = (icnt_q > N_IMG) ? N_IMG : icnt_q;
      kk  = (klim_q > N_TOP) ? N_TOP : klim_q;
      pct = (pct_q > 100) ? 100 : pct_q;
      thr = (pct * count) / 100;
      got = 0;
      foreach (picked[i]) picked[i] = 1'b0;
      for (int r = 0; r < kk; r++) begin
         have = 1'b0;
         best = 0;
         for (int i = 0; i < n; i++) begin
            if (!picked[i] && (!have || votes[i] > votes[best])) begin
               best = i;
               have = 1'b1;
            end
         end
         if (!have || votes[best] <= thr) break;
         picked[best] = 1'b1;
         p = '{best[7:0], votes[best], 1'b1, 1'b0};
         picks_q = {picks_q, p};
         got++;
      end
      if (got == 0) begin
         p = '{8'd0, 16'd0, 1'b0, 1'b1};
         picks_q = {picks_q, p};
      end else begin
         picks_q[picks_q.size()-1].last = 1'b1;
      end
      foreach (votes[i]) votes[i] = '0;
   endfunction

   // Effect of one accepted word on the predictor.
   function automatic void predict_word(cmd_type cmd, logic [REQ_W-1:0] d);
      int n;
      n = (icnt_q > N_IMG) ? N_IMG : icnt_q;
      case (cmd)
         CMD_LOAD: begin
            range_ends[d[7:0]] = d[31:8];
         end
         CMD_MATCH: begin
            if (d[87:56] < dthr_q) begin
               for (int i = 0; i < n; i++) begin
                  if (range_ends[i] > d[55:32]) begin
                     if (votes[i] != VOTE_MAX) votes[i]++;
                     break;
                  end
               end
            end
         end
         CMD_FINISH: predict_finish(d[103:88]);
         default: ;
      endcase
   endfunction

   // Offer one word, possibly after a random gap, and predict it on acceptance.
   task automatic send_word(cmd_type cmd, logic [SLOT_W-1:0] slot, logic [IDX_W-1:0] rend,
                            logic [IDX_W-1:0] idx, logic [DIST_W-1:0] nbr_dist,
                            logic [COUNT_W-1:0] count);
      logic [REQ_W-1:0] d;
      d = {count, nbr_dist, idx, rend, slot};
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      predict_word(cmd, d);
   endtask

   task automatic send_load(int slot, int rend);
      send_word(CMD_LOAD, slot[7:0], rend[23:0], IDX_W'($urandom), $urandom,
                COUNT_W'($urandom));
   endtask

   task automatic send_match(int idx, logic [DIST_W-1:0] nbr_dist);
      send_word(CMD_MATCH, SLOT_W'($urandom), IDX_W'($urandom), idx[23:0], nbr_dist,
                COUNT_W'($urandom));
   endtask

   task automatic send_finish(int count);
      send_word(CMD_FINISH, SLOT_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                $urandom, count[15:0]);
   endtask

   task automatic send_unused();
      send_word(CMD_NONE, SLOT_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                $urandom, COUNT_W'($urandom));
   endtask

   // Wait until every pick has arrived and the block has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (picks_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [DIST_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_IMAGE_COUNT: icnt_q = value[ICNT_W-1:0];
         CSR_K_LIMIT:     klim_q = value[KLIM_W-1:0];
         CSR_MIN_PCT:     pct_q  = value[PCT_W-1:0];
         default:         dthr_q = value;
      endcase
   endtask

   // Block must be idle; all four registers are written in one go.
   task automatic set_config(int icnt, int klim, int pct, logic [DIST_W-1:0] dthr);
      drain();
      write_reg(CSR_IMAGE_COUNT, icnt);
      write_reg(CSR_K_LIMIT, klim);
      write_reg(CSR_MIN_PCT, pct);
      write_reg(CSR_DIST_THR, dthr);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random match distance, mostly under the threshold.
   function automatic logic [DIST_W-1:0] pick_dist();
      if (dthr_q != 0 && $urandom_range(99) < 80) return $urandom_range(dthr_q - 1, 0);
      return $urandom;
   endfunction

   // Default registers, the full range table and the threshold edges.
   task automatic test_defaults();
      int rend;
      rend = 0;
      for (int s = 0; s < N_IMG; s++) begin
         rend += $urandom_range(40, 1);
         send_load(s, rend);
      end
      send_match(0, 32'd0);
      send_match(0, 32'd3276);
      send_match(0, 32'd3277);
      send_match(0, 32'hFFFF_FFFF);
      send_match(int'(range_ends[0]), 32'd1);
      send_match(range_ends[255] - 1, 32'd2);
      send_match(int'(range_ends[255]), 32'd3);
      send_match('hFF_FFFF, 32'd0);
      send_match(int'(range_ends[10]), 32'd0);
      send_unused();
      send_finish(0);
      send_finish('hFFFF);
      send_load(255, 'hFF_FFFF);
      send_match('hFF_FFFE, 32'd0);
      send_match('hFF_FFFE, 32'd0);
      send_finish(0);
      send_load(255, rend);
   endtask

   // Register extremes, including values that saturate or disable the block.
   task automatic test_config_extremes();
      set_config(0, 16, 0, 32'hFFFF_FFFF);
      send_match(0, 32'd0);
      send_finish(0);
      set_config(1, 1, 100, 32'd0);
      send_match(0, 32'd0);
      send_finish(0);
      set_config(511, 31, 127, 32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++) begin
         send_match($urandom_range(int'(range_ends[255])), 32'hFFFF_FFFE);
      end
      send_finish(4);
      set_config(256, 0, 50, 32'd5000);
      send_match(0, 32'd4999);
      send_finish(0);
      set_config(3, 2, 100, 32'd100);
      repeat (3) send_match(int'(range_ends[0]), 32'd0);
      send_match(range_ends[0] - 1, 32'd0);
      send_finish(3);
      set_config(3, 2, 0, 32'd100);
      send_match(int'(range_ends[1]), 32'd0);
      send_match(int'(range_ends[0]), 32'd0);
      send_finish(65535);
   endtask

   // Random traffic under one idling setting.
   task automatic test_random_phase(int idle, int stall, int words);
      int n, sel, hi;
      set_config($urandom_range(99) < 20 ? $urandom_range(256, 1) : $urandom_range(24, 2),
                 $urandom_range(N_TOP, 1), $urandom_range(100), $urandom_range(6000, 1));
      send_idle_pct = idle;
      stall_pct = stall;
      n = (icnt_q > N_IMG) ? N_IMG : icnt_q;
      for (int w = 0; w < words; w++) begin
         sel = $urandom_range(99);
         hi = range_ends[n-1] + 2;
         if (sel < 75) begin
            send_match($urandom_range(hi), pick_dist());
         end else if (sel < 83) begin
            sel = $urandom_range(n - 1);
            send_load(sel, (sel == 0 ? 0 : range_ends[sel-1]) + $urandom_range(60, 1));
         end else if (sel < 93) begin
            send_finish($urandom_range(99) < 70 ? $urandom_range(40) : $urandom);
         end else if (sel < 97) begin
            send_unused();
         end else begin
            send_match($urandom, $urandom);
         end
      end
      send_finish($urandom_range(20));
      drain();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   // Receiver holds off while finishes pile up behind it.
   task automatic test_backpressure();
      set_config(8, 4, 0, 32'hFFFF_FFFF);
      ->hold_go;
      for (int i = 0; i < 6; i++) begin
         repeat (4) send_match($urandom_range(int'(range_ends[7])), 32'd0);
         send_finish(0);
      end
      drain();
   endtask

   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_NONE;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_IMAGE_COUNT;
      csr_data   <= '0;
      icnt_q = ICNT_RST;
      klim_q = KLIM_RST;
      pct_q  = PCT_RST;
      dthr_q = DTHR_RST;
      foreach (votes[i]) votes[i] = '0;
      foreach (range_ends[i]) range_ends[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_config_extremes();
      test_random_phase(0, 0, 20);
      test_random_phase(86, 0, 20);
      test_random_phase(0, 86, 20);
      test_random_phase(12, 12, 20);
      test_backpressure();

      drain();
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/mvt_pkg.sv
hw/rtl/mvt_front.sv
hw/rtl/mvt_queue.sv
hw/rtl/mvt_back.sv
hw/rtl/match_vote_topk_select.sv
tb/tb_match_vote_topk_select.sv
